>>> design/sscc_pkg.sv
// Shared widths, payload structs and side-band types for the sphere contact pipeline.
package sscc_pkg;

  localparam int CoordW  = 32;  // coordinate width
  localparam int RadW    = 31;  // radius width
  localparam int DiffW   = 33;  // difference and magnitude width
  localparam int SqW     = 66;  // squared length width
  localparam int RootW   = 33;  // length width
  localparam int SqRemW  = 37;  // square root remainder width
  localparam int NumW    = 49;  // scaled dividend width
  localparam int QuoW    = 17;  // quotient bits below the overflow check
  localparam int DivW    = 51;  // divider remainder width
  localparam int NormW   = 16;  // Q1.15 normal width
  localparam int DepthW  = 32;  // depth and radius sum width
  localparam int NormFrac = 15; // fraction bits of the normal

  localparam logic [QuoW-1:0] PosMax = QuoW'(32767);
  localparam logic [QuoW-1:0] NegMax = QuoW'(32768);

  typedef struct packed {
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
    logic signed [CoordW-1:0] first_z;
    logic        [RadW-1:0]   first_radius;
    logic signed [CoordW-1:0] second_x;
    logic signed [CoordW-1:0] second_y;
    logic signed [CoordW-1:0] second_z;
    logic        [RadW-1:0]   second_radius;
  } in_t;

  typedef struct packed {
    logic                    hit;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic        [DepthW-1:0] depth;
  } out_t;

  typedef struct packed {
    logic [DiffW-1:0]  mag_x;
    logic [DiffW-1:0]  mag_y;
    logic [DiffW-1:0]  mag_z;
    logic              neg_x;
    logic              neg_y;
    logic              neg_z;
    logic [DepthW-1:0] rsum;
  } side_t;

endpackage

>>> design/sscc_front.sv
// Front end: difference vector, radius sum, squares and squared length.
module sscc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  sscc_pkg::in_t             in_data,
  output logic                      out_valid,
  output logic [sscc_pkg::SqW-1:0]  out_rad,
  output sscc_pkg::side_t           out_side
);
  import sscc_pkg::*;

  logic signed [DiffW-1:0] dx, dy, dz;
  side_t            s1_side_nxt;
  logic             s1_v_r, s2_v_r, s3_v_r;
  side_t            s1_side_r, s2_side_r, s3_side_r;
  logic [SqW-1:0]   sq_x_r, sq_y_r, sq_z_r;
  logic [SqW-1:0]   rad_r;

  // Form differences and magnitudes
  always_comb begin
    dx = DiffW'(in_data.first_x) - DiffW'(in_data.second_x);
    dy = DiffW'(in_data.first_y) - DiffW'(in_data.second_y);
    dz = DiffW'(in_data.first_z) - DiffW'(in_data.second_z);
    s1_side_nxt.neg_x = dx[DiffW-1];
    s1_side_nxt.neg_y = dy[DiffW-1];
    s1_side_nxt.neg_z = dz[DiffW-1];
    s1_side_nxt.mag_x = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
    s1_side_nxt.mag_y = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
    s1_side_nxt.mag_z = dz[DiffW-1] ? DiffW'(-dz) : DiffW'(dz);
    s1_side_nxt.rsum  = DepthW'(in_data.first_radius) + DepthW'(in_data.second_radius);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Square each component, then sum
  always_ff @(posedge clk) begin
    s1_side_r <= s1_side_nxt;
    s2_side_r <= s1_side_r;
    sq_x_r    <= SqW'(s1_side_r.mag_x) * SqW'(s1_side_r.mag_x);
    sq_y_r    <= SqW'(s1_side_r.mag_y) * SqW'(s1_side_r.mag_y);
    sq_z_r    <= SqW'(s1_side_r.mag_z) * SqW'(s1_side_r.mag_z);
    s3_side_r <= s2_side_r;
    rad_r     <= sq_x_r + sq_y_r + sq_z_r;
  end

  assign out_valid = s3_v_r;
  assign out_rad   = rad_r;
  assign out_side  = s3_side_r;

endmodule

>>> design/sscc_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module sscc_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [sscc_pkg::SqW-1:0]   in_rad,
  input  sscc_pkg::side_t            in_side,
  output logic                       out_valid,
  output logic [sscc_pkg::RootW-1:0] out_root,
  output sscc_pkg::side_t            out_side
);
  import sscc_pkg::*;

  logic              v_r    [1:RootW];
  logic [SqW-1:0]    rad_r  [1:RootW];
  logic [SqRemW-1:0] rem_r  [1:RootW];
  logic [RootW-1:0]  root_r [1:RootW];
  side_t             side_r [1:RootW];

  for (genvar i = 0; i < RootW; i++) begin : g_stage
    logic              pv;
    logic [SqW-1:0]    prad;
    logic [SqRemW-1:0] prem, cur, trial;
    logic [RootW-1:0]  proot;
    side_t             pside;
    logic              ge;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prad  = in_rad;
      assign prem  = '0;
      assign proot = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v_r[i];
      assign prad  = rad_r[i];
      assign prem  = rem_r[i];
      assign proot = root_r[i];
      assign pside = side_r[i];
    end

    // Bring down two radicand bits and try the next root bit
    assign cur   = {prem[SqRemW-3:0], prad[SqW-1 -: 2]};
    assign trial = SqRemW'({proot, 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[i+1]  <= prad << 2;
      rem_r[i+1]  <= ge ? cur - trial : cur;
      root_r[i+1] <= {proot[RootW-2:0], ge};
      side_r[i+1] <= pside;
    end
  end

  assign out_valid = v_r[RootW];
  assign out_root  = root_r[RootW];
  assign out_side  = side_r[RootW];

endmodule

>>> design/sscc_div.sv
// Pipelined restoring divider for one normal lane, overflow check then one bit per stage.
module sscc_div (
  input  logic                       clk,
  input  logic [sscc_pkg::NumW-1:0]  num,
  input  logic [sscc_pkg::RootW-1:0] den,
  output logic [sscc_pkg::QuoW-1:0]  quo,
  output logic                       ovf
);
  import sscc_pkg::*;

  logic [DivW-1:0]  rem_r [0:QuoW];
  logic [RootW-1:0] den_r [0:QuoW];
  logic [QuoW-1:0]  quo_r [0:QuoW];
  logic             ovf_r [0:QuoW];

  // Flag quotients that do not fit the quotient bits
  always_ff @(posedge clk) begin
    rem_r[0] <= DivW'(num);
    den_r[0] <= den;
    quo_r[0] <= '0;
    ovf_r[0] <= DivW'(num) >= (DivW'(den) << QuoW);
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_bit
    logic [DivW-1:0] sh;
    logic            ge;
    assign sh = DivW'(den_r[k-1]) << (QuoW - k);
    assign ge = rem_r[k-1] >= sh;

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? rem_r[k-1] - sh : rem_r[k-1];
      den_r[k] <= den_r[k-1];
      quo_r[k] <= {quo_r[k-1][QuoW-2:0], ge};
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  assign quo = quo_r[QuoW];
  assign ovf = ovf_r[QuoW];

endmodule

>>> design/sscc_norm.sv
// Back end: hit test, depth, normal division, saturation and the result register.
module sscc_norm (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [sscc_pkg::RootW-1:0] in_len,
  input  sscc_pkg::side_t            in_side,
  output logic                       out_valid,
  output sscc_pkg::out_t             out_data
);
  import sscc_pkg::*;

  localparam int Dly = QuoW + 1;

  logic              a_v_r, a_hit_r, a_zero_r;
  logic [DepthW-1:0] a_depth_r;
  logic [NumW-1:0]   a_num_x_r, a_num_y_r, a_num_z_r;
  logic [RootW-1:0]  a_len_r;
  logic [2:0]        a_neg_r;

  logic              d_v_r     [1:Dly];
  logic              d_hit_r   [1:Dly];
  logic              d_zero_r  [1:Dly];
  logic [DepthW-1:0] d_depth_r [1:Dly];
  logic [2:0]        d_neg_r   [1:Dly];

  logic [QuoW-1:0]   q_x, q_y, q_z;
  logic              o_x, o_y, o_z;
  logic              out_v_r;
  out_t              out_r, out_nxt;

  // Compare length against the radius sum and scale the dividends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_hit_r   <= in_len < RootW'(in_side.rsum);
    a_zero_r  <= (in_len == '0);
    a_depth_r <= in_side.rsum - in_len[DepthW-1:0];
    a_len_r   <= in_len;
    a_neg_r   <= {in_side.neg_x, in_side.neg_y, in_side.neg_z};
    a_num_x_r <= NumW'({in_side.mag_x, NormFrac'(0)}) + NumW'(in_len[RootW-1:1]);
    a_num_y_r <= NumW'({in_side.mag_y, NormFrac'(0)}) + NumW'(in_len[RootW-1:1]);
    a_num_z_r <= NumW'({in_side.mag_z, NormFrac'(0)}) + NumW'(in_len[RootW-1:1]);
  end

  sscc_div u_div_x (.clk(clk), .num(a_num_x_r), .den(a_len_r), .quo(q_x), .ovf(o_x));
  sscc_div u_div_y (.clk(clk), .num(a_num_y_r), .den(a_len_r), .quo(q_y), .ovf(o_y));
  sscc_div u_div_z (.clk(clk), .num(a_num_z_r), .den(a_len_r), .quo(q_z), .ovf(o_z));

  // Hold side data alongside the dividers
  for (genvar k = 1; k <= Dly; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v_r[k] <= 1'b0;
      end else begin
        d_v_r[k] <= (k == 1) ? a_v_r : d_v_r[k == 1 ? 1 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      d_hit_r[k]   <= (k == 1) ? a_hit_r   : d_hit_r[k == 1 ? 1 : k-1];
      d_zero_r[k]  <= (k == 1) ? a_zero_r  : d_zero_r[k == 1 ? 1 : k-1];
      d_depth_r[k] <= (k == 1) ? a_depth_r : d_depth_r[k == 1 ? 1 : k-1];
      d_neg_r[k]   <= (k == 1) ? a_neg_r   : d_neg_r[k == 1 ? 1 : k-1];
    end
  end

  // Apply sign and saturate one component
  function automatic logic [NormW-1:0] sat_comp(input logic [QuoW-1:0] q, input logic o,
                                                input logic neg);
    logic [QuoW-1:0] m;
    begin
      if (neg) begin
        m = (o || q > NegMax) ? NegMax : q;
        sat_comp = NormW'(-m);
      end else begin
        m = (o || q > PosMax) ? PosMax : q;
        sat_comp = NormW'(m);
      end
    end
  endfunction

  // Assemble the result beat
  always_comb begin
    out_nxt = '0;
    if (d_hit_r[Dly]) begin
      out_nxt.hit   = 1'b1;
      out_nxt.depth = d_depth_r[Dly];
      if (!d_zero_r[Dly]) begin
        out_nxt.normal_x = sat_comp(q_x, o_x, d_neg_r[Dly][2]);
        out_nxt.normal_y = sat_comp(q_y, o_y, d_neg_r[Dly][1]);
        out_nxt.normal_z = sat_comp(q_z, o_z, d_neg_r[Dly][0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= d_v_r[Dly];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

>>> design/sphere_sphere_contact.sv
// Stages from the accepting edge to the result strobe: 3 front, 33 root, 1 compare,
// 18 divide and 1 output register.
// Throughput: one beat per cycle; busy stays low, since every stage advances each cycle.
// The 33-stage square root and the 18-stage lane dividers set the depth.
// Reset: synchronous, active low; clears every valid bit, so beats in flight are dropped.
// The receiver cannot stall; each result is shown for exactly one cycle.
module sphere_sphere_contact (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  sscc_pkg::in_t   in_data,
  output logic            out_valid,
  output sscc_pkg::out_t  out_data
);
  import sscc_pkg::*;

  logic             f_v, r_v;
  logic [SqW-1:0]   f_rad;
  side_t            f_side, r_side;
  logic [RootW-1:0] r_len;

  // Accept a beat whenever start is high
  assign busy = 1'b0;

  sscc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start & ~busy), .in_data(in_data),
    .out_valid(f_v), .out_rad(f_rad), .out_side(f_side)
  );

  sscc_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .in_valid(f_v), .in_rad(f_rad), .in_side(f_side),
    .out_valid(r_v), .out_root(r_len), .out_side(r_side)
  );

  sscc_norm u_norm (
    .clk(clk), .rst_n(rst_n), .in_valid(r_v), .in_len(r_len), .in_side(r_side),
    .out_valid(out_valid), .out_data(out_data)
  );

endmodule

>>> design/sscc_chk.sv
// Port checker for the sphere contact block and its bind.
module sscc_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           busy,
  input logic           out_valid,
  input sscc_pkg::out_t out_data
);
  import sscc_pkg::*;

  // Never refuse a beat
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
    else $error("result right after reset");

  // A miss carries no normal and no depth
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |->
      out_data.depth == 0 && out_data.normal_x == 0 &&
      out_data.normal_y == 0 && out_data.normal_z == 0)
    else $error("miss with payload");

  // A hit always has positive depth
  a_hit_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.depth != 0)
    else $error("hit with zero depth");

endmodule

bind sphere_sphere_contact sscc_chk u_sscc_chk (.*);

>>> tb/sv/sphere_sphere_contact_tb.sv
// Self-checking testbench for the sphere contact pipeline: predicts each contact result.
module sphere_sphere_contact_tb;
  import sscc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  out_t contact_q[$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   idle_on = 1'b1;
  localparam int CycleLimit = 400000;

  sphere_sphere_contact dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count cycles and stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Floor of the square root of a 66-bit sum, bit by bit.
  function automatic logic [32:0] floor_root(logic [65:0] s);
    logic [32:0] r;
    logic [32:0] c;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      c = r | (33'd1 << b);
      if ({33'd0, c} * {33'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  // One Q1.15 component: rounded magnitude ratio, saturated, signed.
  function automatic logic [15:0] unit_comp(logic signed [32:0] d, logic [32:0] len);
    logic [32:0] m;
    logic [63:0] q;
    if (len == 0) return '0;
    m = d[32] ? 33'(-d) : 33'(d);
    q = (({31'd0, m} << 15) + {31'd0, len >> 1}) / {31'd0, len};
    if (d[32]) begin
      if (q > 64'd32768) q = 64'd32768;
      return 16'(-q);
    end
    if (q > 64'd32767) q = 64'd32767;
    return q[15:0];
  endfunction

  function automatic out_t contact_of(in_t a);
    logic signed [32:0] dx, dy, dz;
    logic [32:0] mx, my, mz, len;
    logic [65:0] s;
    logic [32:0] rs;
    out_t r;
    dx = 33'(a.first_x) - 33'(a.second_x);
    dy = 33'(a.first_y) - 33'(a.second_y);
    dz = 33'(a.first_z) - 33'(a.second_z);
    mx = dx[32] ? 33'(-dx) : 33'(dx);
    my = dy[32] ? 33'(-dy) : 33'(dy);
    mz = dz[32] ? 33'(-dz) : 33'(dz);
    s = {33'd0, mx} * {33'd0, mx} + {33'd0, my} * {33'd0, my} + {33'd0, mz} * {33'd0, mz};
    len = floor_root(s);
    rs = {2'b0, a.first_radius} + {2'b0, a.second_radius};
    r = '0;
    if (len < rs) begin
      r.hit = 1'b1;
      r.normal_x = unit_comp(dx, len);
      r.normal_y = unit_comp(dy, len);
      r.normal_z = unit_comp(dz, len);
      r.depth = 32'(rs - len);
    end
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("error: %s got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid) begin
      if (contact_q.size() == 0) report("unexpected beat", longint'(out_data.depth), 64'd0);
      else begin
        e = contact_q.pop_front();
        if (out_data.hit !== e.hit)
          report("hit", longint'(out_data.hit), longint'(e.hit));
        if (out_data.normal_x !== e.normal_x)
          report("normal_x", longint'(out_data.normal_x), longint'(e.normal_x));
        if (out_data.normal_y !== e.normal_y)
          report("normal_y", longint'(out_data.normal_y), longint'(e.normal_y));
        if (out_data.normal_z !== e.normal_z)
          report("normal_z", longint'(out_data.normal_z), longint'(e.normal_z));
        if (out_data.depth !== e.depth)
          report("depth", longint'(out_data.depth), longint'(e.depth));
      end
    end
  end

  // Send one beat, with an optional random gap before it.
  task automatic send_pair(in_t a);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    contact_q.push_back(contact_of(a));
    @(negedge clk);
  endtask

  task automatic pause_line();
    start <= 1'b0;
    while (contact_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic in_t rand_pair();
    in_t a;
    a.first_x = rand_coord();
    a.first_y = $urandom_range(0, 1) ? rand_coord() : a.first_x + $urandom_range(0, 9999);
    a.first_z = rand_coord();
    a.second_x = $urandom_range(0, 1) ? rand_coord() : a.first_x - $urandom_range(0, 1 << 18);
    a.second_y = $urandom_range(0, 1) ? rand_coord() : a.first_y;
    a.second_z = $urandom_range(0, 1) ? rand_coord() : a.first_z + $urandom_range(0, 1 << 18);
    a.first_radius = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 1 << 19));
    a.second_radius = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 1 << 19));
    return a;
  endfunction

  task automatic test_directed();
    in_t a;
    a = '0;
    send_pair(a);                       // coincident, zero radii: no hit
    a.first_radius = 31'd1;
    send_pair(a);                       // coincident with hit: zero normal
    a = '0;
    a.first_x = 32'sh7fffffff; a.second_x = 32'sh80000000;
    a.first_radius = '1; a.second_radius = '1;
    send_pair(a);                       // widest x gap, largest radii
    a.first_x = 32'sh80000000; a.second_x = 32'sh7fffffff;
    send_pair(a);                       // reversed x gap, largest radii: no hit
    a = '0;
    a.first_y = 32'sh80000000; a.second_y = 32'sh7fffffff;
    a.first_z = 32'sh7fffffff; a.second_z = 32'sh80000000;
    a.first_radius = '1; a.second_radius = '1;
    send_pair(a);
    a = '0;
    a.first_x = 32'h10000; a.first_y = 32'h10000; a.first_z = 32'h10000;
    a.first_radius = 31'h20000;
    send_pair(a);                       // diagonal, rounded components
    a.second_radius = 31'd0; a.first_radius = 31'd110850;
    send_pair(a);                       // radius sum just below the length: no hit
    a.first_x = 32'hffff0000; a.first_y = 32'd0; a.first_z = 32'd0;
    a.first_radius = 31'h10000;
    send_pair(a);                       // touching: depth zero, no hit
    a.first_radius = 31'h10001;
    send_pair(a);
    a = '1;
    send_pair(a);
    pause_line();
  endtask

  task automatic test_random(int n, bit gaps);
    idle_on = gaps;
    for (int i = 0; i < n; i++) begin
      send_pair(rand_pair());
      if (gaps && i == n / 2) pause_line();
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(1200, 1'b1);
    test_random(400, 1'b0);
    start <= 1'b0;
    while (contact_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
design/sscc_pkg.sv
design/sscc_front.sv
design/sscc_isqrt.sv
design/sscc_div.sv
design/sscc_norm.sv
design/sphere_sphere_contact.sv
design/sscc_chk.sv
tb/sv/sphere_sphere_contact_tb.sv
